@@ src/odq_pkg.sv @@
`default_nettype none

package odq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed field widths of the stream beats.
  localparam int FUNC_W   = 3;
  localparam int ITEM_W   = 32;
  localparam int STATUS_W = 2;
  localparam int MPOS_W   = 4;
  localparam int ECNT_W   = 5;
  localparam int OUT_W    = 16;  // 12 bits of fields padded to two bytes

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_HEAD = 3'd0,
    FN_INS_TAIL = 3'd1,
    FN_REM_HEAD = 3'd2,
    FN_REM_TAIL = 3'd3,
    FN_SEARCH   = 3'd4,
    FN_REM_VAL  = 3'd5,
    FN_CLEAR    = 3'd6,
    FN_NOP      = 3'd7
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // What every cell does with its stored value on a clock edge.
  typedef enum logic [2:0] {
    CC_HOLD       = 3'd0,
    CC_FROM_LEFT  = 3'd1,  // shift toward the tail, cell 0 takes the key
    CC_LOAD_TAIL  = 3'd2,  // the cell at position count takes the key
    CC_FROM_RIGHT = 3'd3,  // shift toward the head
    CC_CLOSE_GAP  = 3'd4   // shift toward the head from the match onward
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      cmp_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ src/odq_cell.sv @@
`default_nettype none

module odq_cell #(
  parameter int VALUE_WIDTH = odq_pkg::VALUE_WIDTH_DEF,
  parameter int CNT_W       = 5,
  parameter int IDX         = 0
) (
  input  wire logic                   clk,
  input  wire odq_pkg::cell_ctl_t     ctl_i,
  input  wire logic [CNT_W-1:0]       count_i,
  input  wire logic [VALUE_WIDTH-1:0] key_i,
  input  wire logic [VALUE_WIDTH-1:0] left_i,
  input  wire logic [VALUE_WIDTH-1:0] right_i,
  input  wire logic                   gap_i,
  output logic      [VALUE_WIDTH-1:0] value_o,
  output logic                        hit_o
);

  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                   hit_r, hit_nxt;
  logic                   occupied;
  logic                   at_tail;

  // Positions at or beyond the count hold stale data and never match.
  assign occupied = CNT_W'(IDX) < count_i;
  assign at_tail  = CNT_W'(IDX) == count_i;

  always_comb begin
    value_nxt = value_r;
    case (ctl_i.cmd)
      odq_pkg::CC_HOLD:       value_nxt = value_r;
      odq_pkg::CC_FROM_LEFT:  value_nxt = left_i;
      odq_pkg::CC_LOAD_TAIL:  value_nxt = at_tail ? key_i : value_r;
      odq_pkg::CC_FROM_RIGHT: value_nxt = right_i;
      odq_pkg::CC_CLOSE_GAP:  value_nxt = gap_i ? right_i : value_r;
      default:                value_nxt = value_r;
    endcase
  end

  assign hit_nxt = ctl_i.cmp_en ? (occupied && (value_r == key_i)) : hit_r;

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    hit_r   <= hit_nxt;
  end

  assign value_o = value_r;
  assign hit_o   = hit_r;

endmodule

`default_nettype wire

@@ src/ordered_deque_with_search_core.sv @@
`default_nettype none

// Insert, remove head or tail, clear and the unused code go from idle straight to the
// execute state; search and remove value first pass a compare state (compare in every
// cell) and a pick state (pick the first hit), then shift and report in execute.
// Operations are handled one at a time: a new beat is taken only in idle, and execute
// waits while the output register waits on out_tready. Synchronous active-low reset
// empties the queue and drops any pending result; stored values are not cleared.
module ordered_deque_with_search_core #(
  parameter int DEPTH       = odq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = odq_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input channel.
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [odq_pkg::ITEM_W-1:0]    in_tdata,   // [31:0] item_value
  input  wire logic [odq_pkg::FUNC_W-1:0]    in_tuser,   // [2:0] func
  // Result channel.
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [1:0] status, [2] found, [6:3] match_position, [11:7] entry_count, rest zero
  output logic      [odq_pkg::OUT_W-1:0]     out_tdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // The sequencer walks each operation through these phases.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_PICK = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  odq_pkg::func_t         func_r;
  logic [VALUE_WIDTH-1:0] key_r;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic                   found_r;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic [DEPTH-1:0]       gap_r;

  logic                   out_valid_r;
  logic [odq_pkg::OUT_W-1:0] out_data_r, out_data_nxt;

  logic                   accept;
  logic                   fire;
  logic [63:0]            item_ext;

  odq_pkg::cell_ctl_t     ctl;
  odq_pkg::cell_cmd_t     exec_cmd;
  odq_pkg::status_t       status;
  logic                   found_eff;

  logic [VALUE_WIDTH-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]       hits;
  logic [DEPTH-1:0]       first_hit;

  logic                   full;
  logic                   empty;
  logic [31:0]            pos_wide;
  logic [31:0]            cnt_wide;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);

  // The result is written only when the output register is free or drains now.
  assign fire = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  // Only the low VALUE_WIDTH bits of the item take part.
  assign item_ext = 64'(in_tdata);

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_tuser == odq_pkg::FN_SEARCH || in_tuser == odq_pkg::FN_REM_VAL) begin
            state_nxt = S_CMP;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_CMP:  state_nxt = S_PICK;
      S_PICK: state_nxt = S_EXEC;
      S_EXEC: begin
        if (fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // First hit in position order: isolate the lowest set bit, then mark every
  // cell from that position toward the tail to close the gap.
  assign first_hit = hits & (~hits + DEPTH'(1));

  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first_hit[i]) begin
        pos_nxt = pos_nxt | POS_W'(i);
      end
    end
  end

  // Operation decode for the final phase.
  assign found_eff = found_r &&
                     (func_r == odq_pkg::FN_SEARCH || func_r == odq_pkg::FN_REM_VAL);

  always_comb begin
    exec_cmd  = odq_pkg::CC_HOLD;
    status    = odq_pkg::ST_DONE;
    count_nxt = count_r;
    case (func_r)
      odq_pkg::FN_INS_HEAD: begin
        if (full) begin
          status = odq_pkg::ST_FULL;
        end else begin
          exec_cmd  = odq_pkg::CC_FROM_LEFT;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      odq_pkg::FN_INS_TAIL: begin
        if (full) begin
          status = odq_pkg::ST_FULL;
        end else begin
          exec_cmd  = odq_pkg::CC_LOAD_TAIL;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      odq_pkg::FN_REM_HEAD: begin
        if (empty) begin
          status = odq_pkg::ST_EMPTY;
        end else begin
          exec_cmd  = odq_pkg::CC_FROM_RIGHT;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      odq_pkg::FN_REM_TAIL: begin
        if (empty) begin
          status = odq_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      odq_pkg::FN_SEARCH: begin
        if (!found_r) begin
          status = odq_pkg::ST_MISSING;
        end
      end
      odq_pkg::FN_REM_VAL: begin
        if (empty) begin
          status = odq_pkg::ST_EMPTY;
        end else if (found_r) begin
          exec_cmd  = odq_pkg::CC_CLOSE_GAP;
          count_nxt = count_r - CNT_W'(1);
        end else begin
          status = odq_pkg::ST_MISSING;
        end
      end
      odq_pkg::FN_CLEAR: count_nxt = '0;
      default: begin
        exec_cmd  = odq_pkg::CC_HOLD;
        count_nxt = count_r;
      end
    endcase
  end

  // Reported fields are the low bits of the position and count, zero-extended first
  // so that any DEPTH works.
  assign pos_wide = found_eff ? 32'(pos_r) : 32'd0;
  assign cnt_wide = 32'(count_nxt);

  always_comb begin
    out_data_nxt       = '0;
    out_data_nxt[1:0]  = status;
    out_data_nxt[2]    = found_eff;
    out_data_nxt[6:3]  = pos_wide[odq_pkg::MPOS_W-1:0];
    out_data_nxt[11:7] = cnt_wide[odq_pkg::ECNT_W-1:0];
  end

  assign ctl.cmd    = fire ? exec_cmd : odq_pkg::CC_HOLD;
  assign ctl.cmp_en = (state_r == S_CMP);

  // The row of cells. Cell 0 is the head; its left neighbor is the key being
  // inserted, and the last cell sees itself on the right.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [VALUE_WIDTH-1:0] left_v;
    logic [VALUE_WIDTH-1:0] right_v;

    if (g == 0) begin : g_head
      assign left_v = key_r;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end

    odq_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .IDX         (g)
    ) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .count_i (count_r),
      .key_i   (key_r),
      .left_i  (left_v),
      .right_i (right_v),
      .gap_i   (gap_r[g]),
      .value_o (cell_val[g]),
      .hit_o   (hits[g])
    );
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= odq_pkg::func_t'(in_tuser);
      key_r  <= item_ext[VALUE_WIDTH-1:0];
    end
    if (state_r == S_PICK) begin
      found_r <= |hits;
      pos_r   <= pos_nxt;
      gap_r   <= ~(first_hit - DEPTH'(1));
    end
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps

// Keeps its own copy of the queue contents, works out the one result that every
// accepted operation must produce, and compares the result beats against it in order.
class deque_scoreboard;
  localparam int DEPTH = odq_pkg::DEPTH_DEF;

  // Result fields as they sit in out_tdata, lowest bits last in this list.
  typedef struct packed {
    logic [odq_pkg::ECNT_W-1:0] entry_count;
    logic [odq_pkg::MPOS_W-1:0] match_position;
    logic                       found;
    odq_pkg::status_t           status;
  } op_result_t;

  logic [odq_pkg::VALUE_WIDTH_DEF-1:0] held_values[$];
  op_result_t                          awaited_results[$];
  int                                  mismatches;

  function int pending();
    return awaited_results.size();
  endfunction

  function void note_op(odq_pkg::func_t op, logic [odq_pkg::ITEM_W-1:0] value);
    op_result_t res;
    int         hit;
    int         n_held;
    logic [odq_pkg::VALUE_WIDTH_DEF-1:0] key;
    key = value[odq_pkg::VALUE_WIDTH_DEF-1:0];
    res = '0;
    res.status = odq_pkg::ST_DONE;
    hit = -1;
    // Searches always look for the first match from the head.
    if (op == odq_pkg::FN_SEARCH || op == odq_pkg::FN_REM_VAL) begin
      for (int i = 0; i < held_values.size(); i++) begin
        if (hit < 0 && held_values[i] == key) hit = i;
      end
    end
    case (op)
      odq_pkg::FN_INS_HEAD: begin
        if (held_values.size() >= DEPTH) res.status = odq_pkg::ST_FULL;
        else held_values.push_front(key);
      end
      odq_pkg::FN_INS_TAIL: begin
        if (held_values.size() >= DEPTH) res.status = odq_pkg::ST_FULL;
        else held_values.push_back(key);
      end
      odq_pkg::FN_REM_HEAD: begin
        if (held_values.size() == 0) res.status = odq_pkg::ST_EMPTY;
        else void'(held_values.pop_front());
      end
      odq_pkg::FN_REM_TAIL: begin
        if (held_values.size() == 0) res.status = odq_pkg::ST_EMPTY;
        else void'(held_values.pop_back());
      end
      odq_pkg::FN_SEARCH: begin
        if (hit < 0) res.status = odq_pkg::ST_MISSING;
      end
      odq_pkg::FN_REM_VAL: begin
        if (held_values.size() == 0) res.status = odq_pkg::ST_EMPTY;
        else if (hit < 0) res.status = odq_pkg::ST_MISSING;
        else held_values.delete(hit);
      end
      odq_pkg::FN_CLEAR: held_values.delete();
      default: ;
    endcase
    if (hit >= 0 && res.status == odq_pkg::ST_DONE) begin
      res.found          = 1'b1;
      res.match_position = hit[odq_pkg::MPOS_W-1:0];
    end
    n_held = held_values.size();
    res.entry_count = n_held[odq_pkg::ECNT_W-1:0];
    awaited_results.push_back(res);
  endfunction

  task report(string what, int got, int want);
    $display("%0t ns: result %s is %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  task check_result(logic [odq_pkg::OUT_W-1:0] beat);
    op_result_t got, want;
    got = beat[$bits(op_result_t)-1:0];
    if (awaited_results.size() == 0) begin
      report("beat with nothing outstanding, tdata", beat, 0);
      return;
    end
    want = awaited_results.pop_front();
    if (got.status !== want.status) report("status", got.status, want.status);
    if (got.found !== want.found) report("found", got.found, want.found);
    if (got.match_position !== want.match_position)
      report("match_position", got.match_position, want.match_position);
    if (got.entry_count !== want.entry_count)
      report("entry_count", got.entry_count, want.entry_count);
    if (beat[odq_pkg::OUT_W-1:$bits(op_result_t)] !== '0)
      report("padding", beat[odq_pkg::OUT_W-1:$bits(op_result_t)], 0);
  endtask
endclass

module testbench;
  import odq_pkg::*;

  localparam int RANDOM_OPS  = 950;
  localparam int HOLD_CYCLES = 300;  // long receiver hold-off to back up the input
  localparam int TAIL_CYCLES = 20;   // idle time after the last result before the end

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ITEM_W-1:0] in_tdata = '0;
  logic [FUNC_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  // While steady is set neither side inserts idle cycles. hold_off_req asks the
  // receiver for one long stall while the sender keeps offering beats.
  bit steady       = 1'b0;
  bit hold_off_req = 1'b0;

  deque_scoreboard sb = new();

  // Value pool for the random part: a handful of values reused many times, so
  // searches and value removals hit often and duplicates exercise first-match order.
  logic [ITEM_W-1:0] value_pool[6];

  ordered_deque_with_search_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Offers one operation and returns at the edge where the beat is taken. Outside
  // the steady stretch it sometimes drops tvalid for a random stretch first. Handshake
  // signals are sampled right after the edge, so they hold their pre-edge values.
  task automatic send_op(func_t op, logic [ITEM_W-1:0] value);
    if (!steady && $urandom_range(99) < 10) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 30);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_op(op, value);
  endtask

  // Random operation mix. While filling, inserts dominate so the queue reaches full;
  // while draining, removals and searches dominate so it runs empty again.
  function automatic func_t pick_op(bit filling);
    int r;
    r = $urandom_range(99);
    if (r >= 98) return FN_NOP;
    if (r >= 96) return FN_CLEAR;
    if (filling) begin
      if (r < 30) return FN_INS_HEAD;
      if (r < 60) return FN_INS_TAIL;
      if (r < 68) return FN_REM_HEAD;
      if (r < 76) return FN_REM_TAIL;
      if (r < 88) return FN_SEARCH;
      return FN_REM_VAL;
    end
    if (r < 10) return FN_INS_HEAD;
    if (r < 20) return FN_INS_TAIL;
    if (r < 40) return FN_REM_HEAD;
    if (r < 58) return FN_REM_TAIL;
    if (r < 76) return FN_SEARCH;
    return FN_REM_VAL;
  endfunction

  function automatic logic [ITEM_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 80) return value_pool[$urandom_range(5)];
    if (r < 85) return '0;
    if (r < 90) return '1;
    return $urandom();
  endfunction

  // Result side: random stalls outside the steady stretch, plus one long hold-off
  // on request, counted here in cycles.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 10);
      end
    end
  end

  // Every result beat taken is checked against the oldest outstanding prediction.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Removals and searches on an empty queue, the unused code,
    // both extreme values, a miss, a fill to full with both inserts rejected,
    // a hit at the last position, a removal from the middle, then clear.
    send_op(FN_REM_HEAD, 32'h0000_0001);
    send_op(FN_REM_TAIL, 32'h0000_0002);
    send_op(FN_REM_VAL, 32'h0000_0000);
    send_op(FN_SEARCH, 32'hFFFF_FFFF);
    send_op(FN_NOP, 32'hA5A5_A5A5);
    send_op(FN_INS_HEAD, 32'h0000_0000);
    send_op(FN_INS_TAIL, 32'hFFFF_FFFF);
    send_op(FN_SEARCH, 32'hFFFF_FFFF);
    send_op(FN_REM_VAL, 32'h0001_2345);
    for (int i = 2; i < odq_pkg::DEPTH_DEF; i++)
      send_op((i % 2) ? FN_INS_HEAD : FN_INS_TAIL, 32'h1000_0000 + i);
    send_op(FN_INS_HEAD, 32'h5555_5555);
    send_op(FN_INS_TAIL, 32'hAAAA_AAAA);
    send_op(FN_SEARCH, 32'h1000_000E);   // last one inserted at the tail
    send_op(FN_REM_VAL, 32'h0000_0000);  // sits in the middle after the head inserts
    send_op(FN_CLEAR, 32'h0000_0000);

    // Random part, alternating fill and drain phases of 48 operations.
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 100 == 0) begin
        foreach (value_pool[k]) value_pool[k] = $urandom();
      end
      if (n == 200) hold_off_req = 1'b1;
      steady = (n >= 500 && n < 700);
      send_op(pick_op((n / 48) % 2 == 0), pick_value());
    end
    in_tvalid <= 1'b0;
    steady = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about a thousand operations.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
